// ===== hw/rtl/wpi_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the waypoint path interpolator.
package wpi_pkg;

    // Default table depth and fixed field widths.
    localparam int MAX_WAYPOINTS_DEF = 64;
    localparam int COORD_W           = 32;
    localparam int TIME_W            = 24;
    localparam int FRAC_W            = 16;
    localparam int WEIGHT_W          = FRAC_W + 1;

    // Operation codes of an input word.
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_INTERP = 3'd0,
        ST_LAST   = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_STORED = 3'd3,
        ST_FULL   = 3'd4
    } t_status;

    // Input word: one command with its operands.
    typedef struct packed {
        logic                      op;
        logic [TIME_W-1:0]         time_value;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } t_in_word;

    // Output word: position and status.
    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        t_status                   status;
    } t_out_word;

    // One stored waypoint as kept in the table memory.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [TIME_W-1:0]         dur;
    } t_waypoint;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic append;
        logic put_full;
        logic put_empty;
        logic start_walk;
        logic fetch;
        logic advance;
        logic put_last;
        logic div_init;
        logic div_step;
        logic blend_mul;
        logic blend_add;
        logic put_interp;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic at_end;
        logic seg_pass;
        logic div_last;
        logic axis_last;
    } t_dp_stat;

endpackage

// ===== hw/rtl/waypoint_path_interpolator_top.sv =====
`timescale 1ns / 1ps
// Top level of the waypoint path interpolator.
//
// Keeps up to MAX_WAYPOINTS waypoints and answers position queries by
// piecewise linear interpolation. A word is taken when start is high and
// busy is low; each word gives exactly one result word on o_word, shown for
// one cycle with o_strobe high, and the receiver must take it then. An
// append, a full table and an empty-table query answer on the cycle after
// acceptance and leave busy low, so a new word may follow at once. A query
// reads the table one entry at a time (fetch, then compare) until it finds
// the segment that holds the query time or reaches the last entry; when it
// ends inside a segment, the weight divider (one quotient bit a cycle) and
// the blend (one shared multiplier, a multiply and then an add per axis)
// follow. The table has no reset pass; it is ready after reset.
module waypoint_path_interpolator_top import wpi_pkg::*; #(
    parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_word,
    output logic      o_strobe,
    output t_out_word o_word
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Controller.
    wpi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_word.op),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // Datapath.
    wpi_dp #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_word   (i_word),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_word   (o_word),
        .o_strobe (o_strobe)
    );

`ifndef SYNTHESIS
    // An accepted append answers on the next cycle.
    a_append_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_word.op == OP_APPEND) |=> o_strobe)
        else $error("append without result word");

    // A query that walked the table ends with its result word.
    a_query_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("query finished without result word");

    // Positions are zero unless the word carries a point.
    a_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_word.status != ST_INTERP && o_word.status != ST_LAST) |->
        (o_word.pos_x == '0 && o_word.pos_y == '0 && o_word.pos_z == '0))
        else $error("nonzero position on a status-only word");
`endif

endmodule

// ===== hw/rtl/wpi_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
module wpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/wpi_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the waypoint path interpolator.
module wpi_ctrl import wpi_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_op,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FETCH = 6'b000010,
        S_EVAL  = 6'b000100,
        S_DIV   = 6'b001000,
        S_MUL   = 6'b010000,
        S_ADD   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                // Appends and an empty-table query finish in the accept cycle.
                if (i_start) begin
                    if (i_op == OP_APPEND) begin
                        if (i_stat.full) begin
                            o_cmd.put_full = 1'b1;
                        end else begin
                            o_cmd.append = 1'b1;
                        end
                    end else if (i_stat.empty) begin
                        o_cmd.put_empty = 1'b1;
                    end else begin
                        o_cmd.start_walk = 1'b1;
                        n_state          = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_EVAL;
            end
            S_EVAL: begin
                // Walk past entry 0 and segments ending before the query time.
                if (i_stat.seg_pass) begin
                    if (i_stat.at_end) begin
                        o_cmd.put_last = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = S_FETCH;
                    end
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.blend_mul = 1'b1;
                n_state         = S_ADD;
            end
            S_ADD: begin
                o_cmd.blend_add = 1'b1;
                if (i_stat.axis_last) begin
                    o_cmd.put_interp = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_state = S_MUL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== hw/rtl/wpi_dp.sv =====
`timescale 1ns / 1ps
// Datapath: waypoint table, segment walk, weight divider and blend multiplier.
module wpi_dp import wpi_pkg::*; #(
    parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_word,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output t_out_word o_word,
    output logic      o_strobe
);

    localparam int AW    = $clog2(MAX_WAYPOINTS);
    localparam int CW    = $clog2(MAX_WAYPOINTS + 1);
    localparam int SW    = TIME_W + AW;
    localparam int STW   = $clog2(FRAC_W);
    localparam int WP_W  = $bits(t_waypoint);
    localparam int PROD_W = COORD_W + 1 + WEIGHT_W + 1;
    localparam logic [CW-1:0]       MAX_COUNT = CW'(MAX_WAYPOINTS);
    localparam logic [STW-1:0]      LAST_STEP = STW'(FRAC_W - 1);
    localparam logic [WEIGHT_W-1:0] W_ONE     = WEIGHT_W'(1) << FRAC_W;

    // Control state.
    logic [CW-1:0]  r_count;
    logic           r_strobe;

    // Walk, divider and blend registers.
    logic [AW-1:0]               r_q;
    logic [TIME_W-1:0]           r_time;
    logic [SW-1:0]               r_cum;
    logic signed [COORD_W-1:0]   r_prev [3];
    logic signed [COORD_W:0]     r_diff [3];
    logic [TIME_W-1:0]           r_rem;
    logic [WEIGHT_W-1:0]         r_quo;
    logic                        r_dzero;
    logic [STW-1:0]              r_step;
    logic [1:0]                  r_axis;
    logic signed [PROD_W-1:0]    r_prod;
    t_out_word                   r_out;

    logic [WP_W-1:0]             w_rd_data;
    t_waypoint                   w_cur;
    logic signed [COORD_W-1:0]   w_cur_c [3];
    logic [SW:0]                 w_end;
    logic [TIME_W-1:0]           w_offset;
    logic                        w_init_bit;
    logic [TIME_W:0]             w_two;
    logic                        w_step_bit;
    logic [TIME_W:0]             w_step_rem;
    logic [WEIGHT_W-1:0]         w_weight;
    logic signed [COORD_W-1:0]   w_blend;
    t_waypoint                   w_new;

    // Waypoint table.
    assign w_new = '{x: i_word.coord_x, y: i_word.coord_y, z: i_word.coord_z,
                     dur: i_word.time_value};

    wpi_ram #(
        .WIDTH (WP_W),
        .DEPTH (MAX_WAYPOINTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.append),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (w_new),
        .i_rd_en   (i_cmd.fetch),
        .i_rd_addr (r_q),
        .o_rd_data (w_rd_data)
    );

    assign w_cur      = t_waypoint'(w_rd_data);
    assign w_cur_c[0] = w_cur.x;
    assign w_cur_c[1] = w_cur.y;
    assign w_cur_c[2] = w_cur.z;

    // End time of the current segment; the first entry's duration is skipped.
    assign w_end = {1'b0, r_cum} + (SW + 1)'(w_cur.dur);

    // Offset into the segment; it never exceeds the segment duration here.
    assign w_offset   = TIME_W'(SW'(r_time) - r_cum);
    assign w_init_bit = (w_offset >= w_cur.dur);

    // One restoring division step per cycle.
    assign w_two      = {r_rem, 1'b0};
    assign w_step_bit = (w_two >= {1'b0, w_cur.dur});
    assign w_step_rem = w_two - (w_step_bit ? {1'b0, w_cur.dur} : '0);

    // A zero-length segment takes full weight on its end point.
    assign w_weight = r_dzero ? W_ONE : r_quo;

    // Start point plus the scaled difference, floored and wrapped.
    assign w_blend = r_prev[r_axis] + COORD_W'(r_prod >>> FRAC_W);

    // Status to the controller.
    assign o_stat.full      = (r_count == MAX_COUNT);
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.at_end    = ((CW'(r_q) + CW'(1)) == r_count);
    assign o_stat.seg_pass  = (r_q == '0) || (w_end < (SW + 1)'(r_time));
    assign o_stat.div_last  = (r_step == LAST_STEP);
    assign o_stat.axis_last = (r_axis == 2'd2);

    // Fill count and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cmd.append) begin
                r_count <= r_count + CW'(1);
            end
            r_strobe <= i_cmd.append | i_cmd.put_full | i_cmd.put_empty |
                        i_cmd.put_last | i_cmd.put_interp;
        end
    end

    // Segment walk.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_walk) begin
            r_time <= i_word.time_value;
            r_cum  <= '0;
            r_q    <= '0;
        end else if (i_cmd.advance) begin
            if (r_q != '0) begin
                r_cum <= w_end[SW-1:0];
            end
            r_q <= r_q + AW'(1);
            for (int i = 0; i < 3; i++) begin
                r_prev[i] <= w_cur_c[i];
            end
        end
    end

    // Weight divider and axis differences.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem   <= w_offset - (w_init_bit ? w_cur.dur : '0);
            r_quo   <= {{FRAC_W{1'b0}}, w_init_bit};
            r_dzero <= (w_cur.dur == '0);
            r_step  <= '0;
            for (int i = 0; i < 3; i++) begin
                r_diff[i] <= {w_cur_c[i][COORD_W-1], w_cur_c[i]} -
                             {r_prev[i][COORD_W-1], r_prev[i]};
            end
        end else if (i_cmd.div_step) begin
            r_rem  <= w_step_rem[TIME_W-1:0];
            r_quo  <= {r_quo[WEIGHT_W-2:0], w_step_bit};
            r_step <= r_step + STW'(1);
        end
    end

    // Blend, one axis at a time through one multiplier.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_axis <= '0;
        end else if (i_cmd.blend_add) begin
            r_axis <= r_axis + 2'd1;
        end
        if (i_cmd.blend_mul) begin
            r_prod <= PROD_W'(r_diff[r_axis]) * PROD_W'($signed({1'b0, w_weight}));
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.append || i_cmd.put_full || i_cmd.put_empty) begin
            r_out.pos_x <= '0;
            r_out.pos_y <= '0;
            r_out.pos_z <= '0;
        end else if (i_cmd.put_last) begin
            r_out.pos_x <= w_cur.x;
            r_out.pos_y <= w_cur.y;
            r_out.pos_z <= w_cur.z;
        end else if (i_cmd.blend_add) begin
            unique case (r_axis)
                2'd0:    r_out.pos_x <= w_blend;
                2'd1:    r_out.pos_y <= w_blend;
                default: r_out.pos_z <= w_blend;
            endcase
        end
        priority if (i_cmd.append) begin
            r_out.status <= ST_STORED;
        end else if (i_cmd.put_full) begin
            r_out.status <= ST_FULL;
        end else if (i_cmd.put_empty) begin
            r_out.status <= ST_EMPTY;
        end else if (i_cmd.put_last) begin
            r_out.status <= ST_LAST;
        end else if (i_cmd.put_interp) begin
            r_out.status <= ST_INTERP;
        end
    end

    assign o_word   = r_out;
    assign o_strobe = r_strobe;

`ifndef SYNTHESIS
    // The fill count never passes the table depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_COUNT)
        else $error("waypoint count above table depth");

    // A stored word comes with exactly one more table entry.
    a_stored_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_out.status == ST_STORED) |-> r_count == $past(r_count) + CW'(1))
        else $error("stored status without count increment");
`endif

endmodule

// ===== sim/tb_waypoint_path_interpolator_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the waypoint path interpolator top level.
module tb_waypoint_path_interpolator_top import wpi_pkg::*; ();

    localparam int DEPTH = MAX_WAYPOINTS_DEF;
    // Wait after the last result, well beyond the longest query.
    localparam int SETTLE_CYCLES = 4 * DEPTH + 64;
    // Slots of the ring of expected results; at most two are ever outstanding.
    localparam int DUE_DEPTH = 16;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_word  i_word = '0;
    logic      o_strobe;
    t_out_word o_word;

    // Local copy of the waypoint table, updated when a word is accepted.
    logic signed [COORD_W-1:0] path_x [DEPTH];
    logic signed [COORD_W-1:0] path_y [DEPTH];
    logic signed [COORD_W-1:0] path_z [DEPTH];
    logic [TIME_W-1:0]         path_dur [DEPTH];
    int                        path_len = 0;

    // Expected result words in a ring, oldest at the read index.
    t_out_word due_ring [DUE_DEPTH];
    int        due_wr = 0;
    int        due_rd = 0;
    t_out_word due_word;
    int        mismatch_count = 0;

    waypoint_path_interpolator_top #(
        .MAX_WAYPOINTS(DEPTH)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_word   (i_word),
        .o_strobe (o_strobe),
        .o_word   (o_word)
    );

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // One axis of the blend: floor((p0 * (65536 - w) + p1 * w) / 65536), wrapped.
    function automatic logic signed [COORD_W-1:0] lerp_axis(
        input logic signed [COORD_W-1:0] p0,
        input logic signed [COORD_W-1:0] p1,
        input longint unsigned wt);
        longint acc;
        acc = longint'(p0) * (longint'(65536) - longint'(wt)) + longint'(p1) * longint'(wt);
        return acc[47:16];
    endfunction

    // Expected result of one word; an append also updates the local table.
    function automatic t_out_word predict_path(input t_in_word w);
        t_out_word         res;
        longint unsigned   elapsed;
        longint unsigned   seg_dur;
        longint unsigned   t_q;
        longint unsigned   wt;
        res = '0;
        if (w.op == OP_APPEND) begin
            if (path_len >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                path_x[path_len]   = w.coord_x;
                path_y[path_len]   = w.coord_y;
                path_z[path_len]   = w.coord_z;
                path_dur[path_len] = w.time_value;
                path_len++;
                res.status = ST_STORED;
            end
            return res;
        end
        if (path_len == 0) begin
            res.status = ST_EMPTY;
            return res;
        end
        // Walk the segments from the second entry; the first duration is never used.
        t_q = 64'(w.time_value);
        elapsed = '0;
        for (int k = 1; k < path_len; k++) begin
            seg_dur = 64'(path_dur[k]);
            if (elapsed + seg_dur >= t_q) begin
                // A zero-length segment gives its end point.
                if (seg_dur == 0) begin
                    wt = 64'd65536;
                end else begin
                    wt = ((t_q - elapsed) << 16) / seg_dur;
                end
                if (wt > 64'd65536) begin
                    wt = 64'd65536;
                end
                res.pos_x  = lerp_axis(path_x[k-1], path_x[k], wt);
                res.pos_y  = lerp_axis(path_y[k-1], path_y[k], wt);
                res.pos_z  = lerp_axis(path_z[k-1], path_z[k], wt);
                res.status = ST_INTERP;
                return res;
            end
            elapsed += seg_dur;
        end
        // A single entry, or a time past the end, returns the last point.
        res.pos_x  = path_x[path_len-1];
        res.pos_y  = path_y[path_len-1];
        res.pos_z  = path_z[path_len-1];
        res.status = ST_LAST;
        return res;
    endfunction

    // End time of segment k, summed from the second entry.
    function automatic longint unsigned seg_end(input int k);
        longint unsigned acc;
        acc = '0;
        for (int j = 1; j <= k; j++) begin
            acc += 64'(path_dur[j]);
        end
        return acc;
    endfunction

    function automatic logic [TIME_W-1:0] clamp_time(input longint unsigned t_raw);
        return (t_raw > 64'hFF_FFFF) ? 24'hFF_FFFF : t_raw[TIME_W-1:0];
    endfunction

    // Coordinates lean toward the extremes and small values.
    function automatic logic signed [COORD_W-1:0] rand_coord();
        int pick;
        pick = $urandom_range(9);
        unique case (pick)
            0: begin
                return 32'sh8000_0000;
            end
            1: begin
                return 32'sh7FFF_FFFF;
            end
            2: begin
                return $signed($urandom_range(131071)) - 32'sd65536;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    // Durations stay short so that the whole path fits the 24-bit query range,
    // except in the last slot, which may take the longest duration.
    function automatic logic [TIME_W-1:0] rand_duration();
        int pick;
        if (path_len == DEPTH - 1) begin
            return $urandom_range(1) ? 24'hFF_FFFF : TIME_W'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 10) begin
            return '0;
        end else if (pick < 20) begin
            return TIME_W'($urandom_range(16'hFFFF));
        end
        return TIME_W'($urandom_range(4095, 1));
    endfunction

    // Random word: mostly queries aimed at segment interiors, ends and the path end.
    function automatic t_in_word random_word();
        t_in_word        w;
        int              pick;
        int              k;
        longint unsigned t_raw;
        w.coord_x = rand_coord();
        w.coord_y = rand_coord();
        w.coord_z = rand_coord();
        pick = $urandom_range(99);
        if (pick < ((path_len < DEPTH) ? 22 : 8)) begin
            w.op = OP_APPEND;
            w.time_value = rand_duration();
            return w;
        end
        w.op = OP_QUERY;
        pick = $urandom_range(99);
        if (path_len < 2 || pick < 10) begin
            t_raw = 64'($urandom_range(24'hFF_FFFF));
        end else if (pick < 22) begin
            k = $urandom_range(path_len - 1, 1);
            t_raw = seg_end(k) + 64'($urandom_range(1));
        end else if (pick < 32) begin
            t_raw = seg_end(path_len - 1) + 64'($urandom_range(3));
        end else begin
            k = $urandom_range(path_len - 1, 1);
            t_raw = seg_end(k - 1) + 64'($urandom_range(path_dur[k]));
        end
        w.time_value = clamp_time(t_raw);
        return w;
    endfunction

    // Present one word and hold it until the block takes it.
    task automatic send_word(input t_in_word w);
        @(negedge i_clk);
        start  <= 1'b1;
        i_word <= w;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        due_ring[due_wr % DUE_DEPTH] = predict_path(w);
        due_wr++;
    endtask

    task automatic send_append(input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y,
                               input logic signed [COORD_W-1:0] z,
                               input logic [TIME_W-1:0] dur);
        t_in_word w;
        w.op         = OP_APPEND;
        w.time_value = dur;
        w.coord_x    = x;
        w.coord_y    = y;
        w.coord_z    = z;
        send_word(w);
    endtask

    task automatic send_query(input logic [TIME_W-1:0] t_q);
        t_in_word w;
        w.op         = OP_QUERY;
        w.time_value = t_q;
        w.coord_x    = $urandom;
        w.coord_y    = $urandom;
        w.coord_z    = $urandom;
        send_word(w);
    endtask

    // Random idle cycles with start low and garbage on the word bus.
    task automatic idle_sender(input int idle_pct);
        logic [127:0] noise;
        while ($urandom_range(99) < idle_pct) begin
            noise = {$urandom, $urandom, $urandom, $urandom};
            @(negedge i_clk);
            start  <= 1'b0;
            i_word <= noise[$bits(t_in_word)-1:0];
        end
    endtask

    // Stop sending and wait until every expected result has arrived.
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (due_wr != due_rd) begin
            @(posedge i_clk);
        end
    endtask

    task automatic check_field(input string field,
                               input logic signed [COORD_W-1:0] want,
                               input logic signed [COORD_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    // Every strobed result word is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (due_wr == due_rd) begin
                $error("result word with none expected: %p", o_word);
                mismatch_count++;
            end else begin
                due_word = due_ring[due_rd % DUE_DEPTH];
                due_rd++;
                check_field("pos_x", due_word.pos_x, o_word.pos_x);
                check_field("pos_y", due_word.pos_y, o_word.pos_y);
                check_field("pos_z", due_word.pos_z, o_word.pos_z);
                check_field("status", COORD_W'(due_word.status), COORD_W'(o_word.status));
            end
        end
    end

    // Queries on an empty table.
    task automatic test_empty_query();
        send_query('0);
        send_query(24'hFF_FFFF);
    endtask

    // One waypoint: every query returns it. Its duration is never used.
    task automatic test_single_waypoint();
        send_append(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 24'hFF_FFFF);
        send_query('0);
        send_query(24'hFF_FFFF);
    endtask

    // A zero-length segment returns its end point; one past it is past the path end.
    task automatic test_zero_length_segment();
        send_append(32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1, '0);
        send_query('0);
        send_query(24'd1);
    endtask

    // Interpolation between extremes, at fractions, segment ends and past the end.
    task automatic test_segment_interp();
        send_append(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd1, 24'd3);
        send_append(32'sh0001_8000, -32'sh0000_4000, 32'sh7FFF_0000, 24'h00_1000);
        send_query('0);
        send_query(24'd1);
        send_query(24'd2);
        send_query(24'd3);
        send_query(24'd2051);
        send_query(24'd4099);
        send_query(24'd4100);
        send_query(24'hFF_FFFF);
    endtask

    // Random traffic in three phases of sender idling.
    task automatic test_random_traffic();
        int idle_pct [3] = '{37, 52, 0};
        for (int p = 0; p < 3; p++) begin
            for (int n = 0; n < 333; n++) begin
                idle_sender(idle_pct[p]);
                send_word(random_word());
                if ($urandom_range(149) == 0) begin
                    drain_results();
                end
            end
            drain_results();
        end
    endtask

    // Fill the table if it is not full yet, then append to a full table and query it.
    task automatic test_full_table();
        while (path_len < DEPTH) begin
            send_append(rand_coord(), rand_coord(), rand_coord(), rand_duration());
        end
        send_append(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 24'hFF_FFFF);
        send_append(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '0);
        send_query('0);
        send_query(24'hFF_FFFF);
    endtask

    // Main sequence.
    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_query();
        test_single_waypoint();
        test_zero_length_segment();
        test_segment_interp();
        drain_results();
        test_random_traffic();
        test_full_table();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("waypoint_path_interpolator_top regression: pass");
        end else begin
            $display("waypoint_path_interpolator_top regression: fail");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("waypoint_path_interpolator_top regression: fail");
        $finish;
    end

endmodule
